[rtl/framed_packet_parser_crc8_defines.svh]
// Assertion macros shared by the framed packet parser RTL.
`ifndef FRAMED_PACKET_PARSER_CRC8_DEFINES_SVH
`define FRAMED_PACKET_PARSER_CRC8_DEFINES_SVH

// Same-cycle check, sampled on the rising clock, off during reset.
`define FPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Next-cycle implication.
`define FPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fpp_pkg.sv]
// Shared types, codes and the CRC-8 byte update for the framed packet parser.
`timescale 1ns / 1ps
`default_nettype none

package fpp_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'hAA;
  localparam logic [7:0] HDR_SECOND  = 8'h55;
  localparam logic [7:0] TAIL_FIRST  = 8'h55;
  localparam logic [7:0] TAIL_SECOND = 8'hAA;
  localparam logic [7:0] CRC_POLY    = 8'h31;
  localparam logic [7:0] CRC_INIT    = 8'h00;

  localparam logic [2:0] STAT_BUSY     = 3'd0;
  localparam logic [2:0] STAT_OK       = 3'd1;
  localparam logic [2:0] STAT_LEN_ERR  = 3'd2;
  localparam logic [2:0] STAT_TAIL_ERR = 3'd3;
  localparam logic [2:0] STAT_CHK_ERR  = 3'd4;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECKSUM_MODE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_CHECK   = 2'd2;

  localparam logic [7:0] MAX_LENGTH_RESET = 8'd64;

  typedef struct packed {
    logic [7:0] max_length;
    logic       checksum_mode;
    logic [7:0] fixed_check_byte;
  } cfg_t;

  // MSB-first CRC-8, no reflection, no final xor.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/fpp_channels.sv]
// Valid/ready channel interfaces for received bytes and parser results.
`timescale 1ns / 1ps
`default_nettype none

interface fpp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpp_tx_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] frame_address;
  logic [7:0] frame_function;
  logic [7:0] frame_length;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;

  modport source (
    output valid, output status, output frame_address, output frame_function,
    output frame_length, output payload_valid, output payload_byte,
    output payload_index, input ready
  );
  modport sink (
    input valid, input status, input frame_address, input frame_function,
    input frame_length, input payload_valid, input payload_byte,
    input payload_index, output ready
  );
endinterface

`default_nettype wire

[rtl/fpp_cfg_regs.sv]
// Configuration register bank: max length, checksum mode, fixed check byte.
`timescale 1ns / 1ps
`default_nettype none

module fpp_cfg_regs
  import fpp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_length       <= MAX_LENGTH_RESET;
      cfg.checksum_mode    <= 1'b0;
      cfg.fixed_check_byte <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_LENGTH:    cfg.max_length       <= cfg_wdata[7:0];
        CFG_CHECKSUM_MODE: cfg.checksum_mode    <= cfg_wdata[0];
        CFG_FIXED_CHECK:   cfg.fixed_check_byte <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/fpp_parser.sv]
// Frame parser state machine with running CRC-8 and registered result stage.
`timescale 1ns / 1ps
`default_nettype none
`include "framed_packet_parser_crc8_defines.svh"

module fpp_parser
  import fpp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  fpp_rx_if.sink    rx,
  fpp_tx_if.source  tx
);

  localparam logic [3:0] ST_HUNT1 = 4'd0;
  localparam logic [3:0] ST_HUNT2 = 4'd1;
  localparam logic [3:0] ST_ADDR  = 4'd2;
  localparam logic [3:0] ST_FUNC  = 4'd3;
  localparam logic [3:0] ST_LEN   = 4'd4;
  localparam logic [3:0] ST_DATA  = 4'd5;
  localparam logic [3:0] ST_CHECK = 4'd6;
  localparam logic [3:0] ST_TAIL1 = 4'd7;
  localparam logic [3:0] ST_TAIL2 = 4'd8;

  logic [3:0] state, state_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] held_address, held_address_next;
  logic [7:0] held_function, held_function_next;
  logic [7:0] held_length, held_length_next;
  logic [7:0] received_check, received_check_next;
  logic [7:0] running_crc, running_crc_next;

  logic [2:0] res_status;
  logic       res_pv;
  logic [7:0] res_pb;
  logic [7:0] res_pi;
  logic [7:0] crc_step;
  logic [7:0] count_inc;
  logic [7:0] expected;
  logic       take;

  // Output register frees up when empty or drained in the same cycle.
  assign rx.ready = !tx.valid || tx.ready;
  assign take     = rx.valid && rx.ready;

  assign crc_step  = crc8_update(running_crc, rx.rx_byte);
  assign count_inc = payload_count + 8'd1;
  assign expected  = cfg.checksum_mode ? cfg.fixed_check_byte : running_crc;

  always_comb begin
    state_next          = state;
    payload_count_next  = payload_count;
    held_address_next   = held_address;
    held_function_next  = held_function;
    held_length_next    = held_length;
    received_check_next = received_check;
    running_crc_next    = running_crc;
    res_status          = STAT_BUSY;
    res_pv              = 1'b0;
    res_pb              = 8'd0;
    res_pi              = 8'd0;
    unique case (state)
      ST_HUNT1: begin
        if (rx.rx_byte == HDR_FIRST) state_next = ST_HUNT2;
      end
      ST_HUNT2: begin
        // a bad second header byte is never reused as a first header byte
        if (rx.rx_byte == HDR_SECOND) begin
          payload_count_next = 8'd0;
          running_crc_next   = CRC_INIT;
          state_next         = ST_ADDR;
        end else begin
          state_next = ST_HUNT1;
        end
      end
      ST_ADDR: begin
        held_address_next = rx.rx_byte;
        running_crc_next  = crc_step;
        state_next        = ST_FUNC;
      end
      ST_FUNC: begin
        held_function_next = rx.rx_byte;
        running_crc_next   = crc_step;
        state_next         = ST_LEN;
      end
      ST_LEN: begin
        held_length_next = rx.rx_byte;
        running_crc_next = crc_step;
        if (rx.rx_byte > cfg.max_length) begin
          res_status = STAT_LEN_ERR;
          state_next = ST_HUNT1;
        end else if (rx.rx_byte == 8'd0) begin
          state_next = ST_CHECK;
        end else begin
          payload_count_next = 8'd0;
          state_next         = ST_DATA;
        end
      end
      ST_DATA: begin
        res_pv             = 1'b1;
        res_pb             = rx.rx_byte;
        res_pi             = payload_count;
        running_crc_next   = crc_step;
        payload_count_next = count_inc;
        if (count_inc >= held_length) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        received_check_next = rx.rx_byte;
        state_next          = ST_TAIL1;
      end
      ST_TAIL1: begin
        if (rx.rx_byte == TAIL_FIRST) begin
          state_next = ST_TAIL2;
        end else begin
          res_status = STAT_TAIL_ERR;
          state_next = ST_HUNT1;
        end
      end
      ST_TAIL2: begin
        if (rx.rx_byte == TAIL_SECOND) begin
          res_status = (expected == received_check) ? STAT_OK : STAT_CHK_ERR;
        end else begin
          res_status = STAT_TAIL_ERR;
        end
        state_next = ST_HUNT1;
      end
      default: begin
        state_next = ST_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_HUNT1;
      payload_count  <= 8'd0;
      held_address   <= 8'd0;
      held_function  <= 8'd0;
      held_length    <= 8'd0;
      received_check <= 8'd0;
      running_crc    <= CRC_INIT;
      tx.valid       <= 1'b0;
    end else begin
      if (take) begin
        state          <= state_next;
        payload_count  <= payload_count_next;
        held_address   <= held_address_next;
        held_function  <= held_function_next;
        held_length    <= held_length_next;
        received_check <= received_check_next;
        running_crc    <= running_crc_next;
        tx.valid       <= 1'b1;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tx.status         <= res_status;
      tx.frame_address  <= held_address_next;
      tx.frame_function <= held_function_next;
      tx.frame_length   <= held_length_next;
      tx.payload_valid  <= res_pv;
      tx.payload_byte   <= res_pb;
      tx.payload_index  <= res_pi;
    end
  end

  `FPP_ASSERT(a_data_count_in_range, (state != ST_DATA) || (payload_count < held_length), "payload count reached length inside payload")
  `FPP_ASSERT(a_payload_index_in_frame, !(tx.valid && tx.payload_valid) || (tx.payload_index < tx.frame_length), "payload index beyond frame length")
  `FPP_ASSERT(a_payload_no_status, !(tx.valid && tx.payload_valid) || (tx.status == STAT_BUSY), "payload item carries a final status")
  `FPP_ASSERT_NEXT(a_tail2_reports, take && (state == ST_TAIL2), tx.valid && (tx.status != STAT_BUSY) && (state == ST_HUNT1), "last tail byte gave no final status")
  `FPP_ASSERT_NEXT(a_stall_holds_state, !take, $stable(state) && $stable(running_crc), "parser state moved without an accepted item")

endmodule

`default_nettype wire

[rtl/framed_packet_parser_crc8.sv]
// Each accepted byte's result item is registered and shown on tx in the next cycle.
// Throughput: one byte per cycle; the single output register is refilled in the
// same cycle it drains, so rx.ready only drops while tx holds an untaken item.
// Per byte: one state machine step; CRC-8 (0x31) update on address to payload.
// Reset (rst, synchronous): hunt for header, counters/held fields/CRC zero,
// max_length 64, CRC mode, fixed byte 0, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_parser_crc8
  import fpp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  fpp_rx_if.sink                      rx,
  fpp_tx_if.source                    tx,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t cfg;

  fpp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fpp_parser u_parser (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .rx  (rx),
    .tx  (tx)
  );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the framed packet parser with CRC-8 check.
`timescale 1ns / 1ps

module tb_top;
  import fpp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD = 300;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    P_HUNT1, P_HUNT2, P_ADDR, P_FUNC, P_LEN, P_DATA, P_CHECK, P_TAIL1, P_TAIL2
  } parse_state_e;

  typedef enum int {CHK_GOOD, CHK_WRONG, CHK_FIXED} check_sel_e;
  typedef enum int {TAIL_GOOD, TAIL_BAD_FIRST, TAIL_BAD_SECOND, TAIL_OPEN} tail_sel_e;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_address;
    logic [7:0] frame_function;
    logic [7:0] frame_length;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } frame_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fpp_rx_if rx_ch ();
  fpp_tx_if tx_ch ();

  framed_packet_parser_crc8 DUT (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .tx(tx_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Parser copy used for prediction
  parse_state_e ps;
  logic [7:0] pay_cnt, hold_addr, hold_func, hold_len, rcv_check, crc_acc;
  logic [7:0] cfg_max;
  logic       cfg_mode;
  logic [7:0] cfg_fixed;

  logic [7:0] rx_bytes[$];
  frame_result_t expected_results[$];

  int burst_left = 0;
  int gap_left = 0;
  int bytes_accepted = 0;
  int frame_bytes = 0;
  int results_checked = 0;
  int payload_seen = 0;
  int n_ok = 0, n_len_err = 0, n_tail_err = 0, n_chk_err = 0;
  int err_count = 0;
  int cycle_count = 0;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  int pat_age = 0;
  logic [15:0] ready_pat = '1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bitwise form: feedback is the top CRC bit xor the incoming data bit.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic frame_result_t predict_parse(input logic [7:0] b);
    frame_result_t r;
    logic [7:0] want_check;
    r = '0;
    r.status = STAT_BUSY;
    case (ps)
      P_HUNT1: begin
        if (b == HDR_FIRST) ps = P_HUNT2;
      end
      P_HUNT2: begin
        if (b == HDR_SECOND) begin
          pay_cnt = 8'd0;
          crc_acc = CRC_INIT;
          ps = P_ADDR;
        end else begin
          ps = P_HUNT1;
        end
      end
      P_ADDR: begin
        hold_addr = b;
        crc_acc = crc8_next(crc_acc, b);
        ps = P_FUNC;
      end
      P_FUNC: begin
        hold_func = b;
        crc_acc = crc8_next(crc_acc, b);
        ps = P_LEN;
      end
      P_LEN: begin
        hold_len = b;
        crc_acc = crc8_next(crc_acc, b);
        if (b > cfg_max) begin
          r.status = STAT_LEN_ERR;
          ps = P_HUNT1;
        end else if (b == 8'd0) begin
          ps = P_CHECK;
        end else begin
          pay_cnt = 8'd0;
          ps = P_DATA;
        end
      end
      P_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        r.payload_index = pay_cnt;
        crc_acc = crc8_next(crc_acc, b);
        pay_cnt = pay_cnt + 8'd1;
        if (pay_cnt >= hold_len) ps = P_CHECK;
      end
      P_CHECK: begin
        rcv_check = b;
        ps = P_TAIL1;
      end
      P_TAIL1: begin
        if (b == TAIL_FIRST) begin
          ps = P_TAIL2;
        end else begin
          r.status = STAT_TAIL_ERR;
          ps = P_HUNT1;
        end
      end
      P_TAIL2: begin
        if (b == TAIL_SECOND) begin
          want_check = cfg_mode ? cfg_fixed : crc_acc;
          r.status = (want_check == rcv_check) ? STAT_OK : STAT_CHK_ERR;
        end else begin
          r.status = STAT_TAIL_ERR;
        end
        ps = P_HUNT1;
      end
      default: ps = P_HUNT1;
    endcase
    r.frame_address = hold_addr;
    r.frame_function = hold_func;
    r.frame_length = hold_len;
    return r;
  endfunction

  task automatic check_result(input frame_result_t want);
    if (tx_ch.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, tx_ch.status);
      err_count++;
    end
    if (tx_ch.frame_address !== want.frame_address) begin
      $error("frame_address: expected %0h, got %0h", want.frame_address, tx_ch.frame_address);
      err_count++;
    end
    if (tx_ch.frame_function !== want.frame_function) begin
      $error("frame_function: expected %0h, got %0h", want.frame_function,
             tx_ch.frame_function);
      err_count++;
    end
    if (tx_ch.frame_length !== want.frame_length) begin
      $error("frame_length: expected %0d, got %0d", want.frame_length, tx_ch.frame_length);
      err_count++;
    end
    if (tx_ch.payload_valid !== want.payload_valid) begin
      $error("payload_valid: expected %0d, got %0d", want.payload_valid, tx_ch.payload_valid);
      err_count++;
    end
    if (tx_ch.payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %0h, got %0h", want.payload_byte, tx_ch.payload_byte);
      err_count++;
    end
    if (tx_ch.payload_index !== want.payload_index) begin
      $error("payload_index: expected %0d, got %0d", want.payload_index, tx_ch.payload_index);
      err_count++;
    end
  endtask

  // Byte driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_ch.rx_byte <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        expected_results.push_back(predict_parse(rx_ch.rx_byte));
        bytes_accepted++;
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_ch.valid <= 1'b0;
        end else if (rx_bytes.size() > 0) begin
          rx_ch.rx_byte <= rx_bytes.pop_front();
          rx_ch.valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      tx_ch.ready <= 1'b0;
    end else begin
      if (tx_ch.valid && tx_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with no byte outstanding");
          err_count++;
        end else begin
          check_result(expected_results.pop_front());
          results_checked++;
          if (tx_ch.payload_valid) payload_seen++;
          case (tx_ch.status)
            STAT_OK: n_ok++;
            STAT_LEN_ERR: n_len_err++;
            STAT_TAIL_ERR: n_tail_err++;
            STAT_CHK_ERR: n_chk_err++;
            default: ;
          endcase
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_asks != hold_done) begin
        hold_left = LONG_HOLD;
        hold_done++;
      end
      if (pat_age == 0) begin
        pat_age = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: ready_pat = '1;
          1: ready_pat = 16'($urandom);
          2: ready_pat = 16'($urandom | $urandom);
          default: ready_pat = 16'($urandom & $urandom);
        endcase
      end else begin
        pat_age--;
      end
      ready_pat = {ready_pat[14:0], ready_pat[15]};
      tx_ch.ready <= (hold_left == 0) && ready_pat[0];
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL framed_packet_parser_crc8");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_LENGTH: cfg_max = val;
      CFG_CHECKSUM_MODE: cfg_mode = val[0];
      CFG_FIXED_CHECK: cfg_fixed = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (rx_bytes.size() != 0 || rx_ch.valid || expected_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Queues one frame; stops after the length byte when the length will be rejected.
  task automatic add_frame(input logic [7:0] addr, input logic [7:0] func,
                           input logic [7:0] len, input check_sel_e ck, input tail_sel_e tl);
    logic [7:0] crc;
    logic [7:0] b;
    logic [7:0] chk;
    crc = CRC_INIT;
    rx_bytes.push_back(HDR_FIRST);
    rx_bytes.push_back(HDR_SECOND);
    rx_bytes.push_back(addr);
    rx_bytes.push_back(func);
    rx_bytes.push_back(len);
    crc = crc8_next(crc8_next(crc8_next(crc, addr), func), len);
    frame_bytes += 5;
    if (len > cfg_max) return;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      rx_bytes.push_back(b);
      crc = crc8_next(crc, b);
    end
    chk = cfg_mode ? cfg_fixed : crc;
    if (ck == CHK_WRONG) chk = chk ^ 8'($urandom_range(1, 255));
    if (ck == CHK_FIXED) chk = cfg_fixed;
    rx_bytes.push_back(chk);
    frame_bytes += len + 1;
    case (tl)
      TAIL_GOOD: begin
        rx_bytes.push_back(TAIL_FIRST);
        rx_bytes.push_back(TAIL_SECOND);
      end
      TAIL_BAD_FIRST: begin
        do b = 8'($urandom); while (b == TAIL_FIRST);
        rx_bytes.push_back(b);
      end
      TAIL_BAD_SECOND: begin
        rx_bytes.push_back(TAIL_FIRST);
        do b = 8'($urandom); while (b == TAIL_SECOND);
        rx_bytes.push_back(b);
      end
      default: rx_bytes.push_back(TAIL_FIRST);
    endcase
    frame_bytes += 2;
  endtask

  function automatic logic [7:0] pick_len();
    int hi;
    hi = (cfg_max < 12) ? cfg_max : 12;
    if ($urandom_range(0, 39) == 0) return 8'($urandom_range(0, cfg_max));
    return 8'($urandom_range(0, hi));
  endfunction

  task automatic run_random(input int target);
    int start_count;
    int pick;
    logic [7:0] b;
    start_count = frame_bytes;
    while (frame_bytes - start_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_frame(8'($urandom), 8'($urandom), pick_len(),
                  ($urandom_range(0, 9) == 0) ? CHK_WRONG : CHK_GOOD, TAIL_GOOD);
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 4)) rx_bytes.push_back(8'($urandom));
      end else if (pick < 84) begin
        rx_bytes.push_back(HDR_FIRST);
        if ($urandom_range(0, 1) == 0) begin
          // a repeated first header byte must not restart the frame
          rx_bytes.push_back(HDR_FIRST);
          rx_bytes.push_back(HDR_SECOND);
        end else begin
          do b = 8'($urandom); while (b == HDR_SECOND);
          rx_bytes.push_back(b);
        end
      end else if (pick < 90 && cfg_max != 8'hFF) begin
        add_frame(8'($urandom), 8'($urandom), 8'($urandom_range(cfg_max + 1, 255)),
                  CHK_GOOD, TAIL_GOOD);
      end else if (pick < 95) begin
        add_frame(8'($urandom), 8'($urandom), pick_len(), CHK_GOOD, TAIL_BAD_FIRST);
      end else begin
        add_frame(8'($urandom), 8'($urandom), pick_len(), CHK_GOOD, TAIL_BAD_SECOND);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    ps = P_HUNT1;
    pay_cnt = '0;
    hold_addr = '0;
    hold_func = '0;
    hold_len = '0;
    rcv_check = '0;
    crc_acc = CRC_INIT;
    cfg_max = MAX_LENGTH_RESET;
    cfg_mode = 1'b0;
    cfg_fixed = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings (max length 64, CRC check)
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    rx_bytes.push_back(HDR_FIRST);
    rx_bytes.push_back(HDR_FIRST);
    rx_bytes.push_back(HDR_SECOND);
    add_frame(8'h00, 8'hFF, 8'd0, CHK_GOOD, TAIL_GOOD);
    add_frame(8'hFF, 8'h00, 8'd1, CHK_GOOD, TAIL_GOOD);
    add_frame(8'h5A, 8'hA5, 8'd65, CHK_GOOD, TAIL_GOOD);
    add_frame(8'h01, 8'h02, 8'd0, CHK_GOOD, TAIL_BAD_FIRST);
    add_frame(8'h03, 8'h04, 8'd0, CHK_GOOD, TAIL_BAD_SECOND);
    add_frame(8'h80, 8'h7F, 8'd2, CHK_WRONG, TAIL_GOOD);
    wait_idle();
    write_reg(CFG_UNUSED, 8'h00);
    add_frame(8'h11, 8'h22, 8'd3, CHK_GOOD, TAIL_GOOD);
    wait_idle();

    // Widest length, fixed check byte all ones
    write_reg(CFG_MAX_LENGTH, 8'hFF);
    write_reg(CFG_CHECKSUM_MODE, 8'd1);
    write_reg(CFG_FIXED_CHECK, 8'hFF);
    add_frame(8'($urandom), 8'($urandom), 8'hFF, CHK_GOOD, TAIL_GOOD);
    run_random(250);
    wait_idle();

    // Zero length only, CRC check, fixed byte back to zero
    write_reg(CFG_MAX_LENGTH, 8'h00);
    write_reg(CFG_CHECKSUM_MODE, 8'd0);
    write_reg(CFG_FIXED_CHECK, 8'h00);
    run_random(150);
    wait_idle();

    // Random limit and fixed byte
    write_reg(CFG_MAX_LENGTH, 8'($urandom_range(1, 254)));
    write_reg(CFG_CHECKSUM_MODE, 8'd1);
    write_reg(CFG_FIXED_CHECK, 8'($urandom));
    write_reg(CFG_UNUSED, 8'($urandom));
    add_frame(8'($urandom), 8'($urandom), cfg_max, CHK_GOOD, TAIL_GOOD);
    run_random(250);
    wait_idle();

    // Settings changed in the middle of a frame
    write_reg(CFG_MAX_LENGTH, 8'd64);
    write_reg(CFG_CHECKSUM_MODE, 8'd0);
    rx_bytes.push_back(HDR_FIRST);
    rx_bytes.push_back(HDR_SECOND);
    rx_bytes.push_back(8'h12);
    rx_bytes.push_back(8'h34);
    wait_idle();
    write_reg(CFG_MAX_LENGTH, 8'd3);
    rx_bytes.push_back(8'd4);
    wait_idle();
    write_reg(CFG_MAX_LENGTH, 8'd64);
    write_reg(CFG_FIXED_CHECK, 8'h5A);
    add_frame(8'h21, 8'h43, 8'd2, CHK_FIXED, TAIL_OPEN);
    wait_idle();
    write_reg(CFG_CHECKSUM_MODE, 8'd1);
    rx_bytes.push_back(TAIL_SECOND);
    wait_idle();

    // Default max length and CRC check, with a long receiver hold-off and a full sender pause
    write_reg(CFG_CHECKSUM_MODE, 8'd0);
    hold_asks++;
    run_random(130);
    wait_idle();
    run_random(130);
    wait_idle();
    repeat (4) @(negedge clk);

    $display("Drove %0d bytes, checked %0d results, %0d of them payload bytes.",
             bytes_accepted, results_checked, payload_seen);
    $display("Frames ok %0d, length errors %0d, tail errors %0d, checksum errors %0d.",
             n_ok, n_len_err, n_tail_err, n_chk_err);
    if (err_count == 0) begin
      $display("PASS framed_packet_parser_crc8");
    end else begin
      $display("FAIL framed_packet_parser_crc8");
    end
    $finish;
  end

endmodule
